// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the glyph decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/gcpd_pkg.sv =====
// Shared types, constants and color blend function for the glyph decoder.
`default_nettype none
package gcpd_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One decoded command, ready for run generation
    typedef struct packed {
        logic        mono;   // one-bit pixel pattern
        logic        two;    // run format with a second run
        logic [14:0] pat;
        logic [3:0]  len;
        logic [11:0] col0;   // mono: color of 0 bits; runs: first run color
        logic [7:0]  cnt0;
        logic [11:0] col1;   // mono: color of 1 bits; runs: second run color
        logic [7:0]  cnt1;
    } t_job;

    // Blend background and foreground by a 4-bit shade into RGB444
    function automatic logic [11:0] gcpd_blend(input logic [23:0] bg,
                                               input logic [23:0] fg,
                                               input logic [3:0]  shade);
        logic [7:0]  w0;
        logic [7:0]  w1;
        logic [16:0] r_sum;
        logic [16:0] g_sum;
        logic [16:0] b_sum;
        w1    = {shade, shade};
        w0    = {~shade, ~shade};
        r_sum = 17'({8'd0, bg[23:16]} * {8'd0, w0}) + 17'({8'd0, fg[23:16]} * {8'd0, w1});
        g_sum = 17'({8'd0, bg[15:8]} * {8'd0, w0}) + 17'({8'd0, fg[15:8]} * {8'd0, w1});
        b_sum = 17'({8'd0, bg[7:0]} * {8'd0, w0}) + 17'({8'd0, fg[7:0]} * {8'd0, w1});
        return {r_sum[15:12], g_sum[15:12], b_sum[15:12]};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/glyph_command_pixel_decoder_top.sv =====
// Glyph command pixel decoder: command words in, RGB444 color runs out.
// A command passes through the front-end job register, the job queue and the output
// register. Throughput: one result per cycle while the output is popped; a command
// causes 1 to 15 results, all from the single run generator.
// Reset (synchronous, active low) empties the queue and output register and
// loads foreground white and background black.
`default_nettype none
module glyph_command_pixel_decoder_top
    import gcpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_command_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [11:0]      o_pixel_color,
    output logic [7:0]       o_repeat_count,
    output logic             o_last_run,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    logic f_valid;
    t_job f_job;
    logic q_ready;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    // Decode requests
    gcpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command_word (i_command_word),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_job_valid    (f_valid),
        .o_job          (f_job),
        .i_job_ready    (q_ready)
    );

    // Buffer decoded jobs
    gcpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // Generate color runs
    gcpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_job_pop      (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_pixel_color  (o_pixel_color),
        .o_repeat_count (o_repeat_count),
        .o_last_run     (o_last_run)
    );

endmodule
`default_nettype wire

// ===== hdl/gcpd_front.sv =====
// Front end: accept command words, decode the format, resolve colors.
`default_nettype none
module gcpd_front
    import gcpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_command_word,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    output logic             o_job_valid,
    output t_job             o_job,
    input  wire logic        i_job_ready
);

    localparam logic       CFG_FG       = 1'b0;
    localparam logic       CFG_BG       = 1'b1;
    localparam logic [2:0] FMT_MONO_N   = 3'b001;
    localparam logic [3:0] FMT_RUNS     = 4'b0100;
    localparam logic [3:0] FMT_SHADE_BG = 4'b0110;
    localparam logic [3:0] FMT_SHADE_FG = 4'b0111;
    localparam logic [3:0] SHADE_BG     = 4'h0;
    localparam logic [3:0] SHADE_FG     = 4'hF;

    logic [23:0] r_fg_rgb;
    logic [23:0] r_bg_rgb;
    logic        r_valid;
    t_job        r_job;

    logic        accept;
    logic        keep;
    t_job        dec;
    logic [11:0] bg_col;
    logic [11:0] fg_col;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_rgb <= 24'hFFFFFF;
            r_bg_rgb <= 24'h000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FG:  r_fg_rgb <= i_cfg_data;
                CFG_BG:  r_bg_rgb <= i_cfg_data;
                default: r_fg_rgb <= r_fg_rgb;
            endcase
        end
    end

    assign bg_col = gcpd_blend(r_bg_rgb, r_fg_rgb, SHADE_BG);
    assign fg_col = gcpd_blend(r_bg_rgb, r_fg_rgb, SHADE_FG);

    // Decode the command into a job and drop it if it emits nothing
    always_comb begin
        dec      = '0;
        dec.col0 = bg_col;
        dec.col1 = fg_col;
        keep     = 1'b0;
        priority if (i_command_word[15]) begin
            dec.mono = 1'b1;
            dec.pat  = i_command_word[14:0];
            dec.len  = 4'd15;
        end else if (i_command_word[15:13] == FMT_MONO_N) begin
            dec.mono = 1'b1;
            dec.pat  = i_command_word[14:0];
            dec.len  = i_command_word[12:9];
        end else if (i_command_word[15:12] == FMT_RUNS) begin
            dec.cnt0 = {2'b00, i_command_word[5:0]};
            dec.cnt1 = {2'b00, i_command_word[11:6]};
        end else if (i_command_word[15:12] == FMT_SHADE_BG
                  || i_command_word[15:12] == FMT_SHADE_FG) begin
            dec.col0 = gcpd_blend(r_bg_rgb, r_fg_rgb, i_command_word[11:8]);
            dec.cnt0 = 8'd1;
            dec.col1 = i_command_word[12] ? fg_col : bg_col;
            dec.cnt1 = i_command_word[7:0];
        end else begin
            dec.cnt0 = 8'd0;
        end

        if (dec.mono) begin
            keep = (dec.len != 4'd0);
        end else begin
            // Close up an empty first run
            if (dec.cnt0 == 8'd0) begin
                dec.cnt0 = dec.cnt1;
                dec.col0 = dec.col1;
                dec.cnt1 = 8'd0;
            end
            dec.two = (dec.cnt1 != 8'd0);
            keep    = (dec.cnt0 != 8'd0);
        end
    end

    assign full   = r_valid && !i_job_ready;
    assign accept = push && !full;

    // Hold the decoded job until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= dec;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule
`default_nettype wire

// ===== hdl/gcpd_queue.sv =====
// Short job queue between the decoder front end and the run generator.
`default_nettype none
`include "assert_macros.svh"
module gcpd_queue
    import gcpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_ready,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic           do_push;
    logic           do_pop;

    assign o_ready = (r_count != QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + QCW'(do_push) - QCW'(do_pop);
        end
    end

    // Store requests
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCW'(QDEPTH))
    `ASSERT_NEXT(a_push_only, i_clk, i_rst_n, do_push && !do_pop, r_count != '0)

endmodule
`default_nettype wire

// ===== hdl/gcpd_back.sv =====
// Back end: head job color runs go to the output register, one per cycle unless held.
`default_nettype none
`include "assert_macros.svh"
module gcpd_back
    import gcpd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    output logic       empty,
    input  wire logic  pop,
    output logic [11:0] o_pixel_color,
    output logic [7:0]  o_repeat_count,
    output logic        o_last_run
);

    logic [3:0]  r_pos;
    logic        r_out_valid;
    logic [11:0] r_out_col;
    logic [7:0]  r_out_cnt;
    logic        r_out_last;

    logic        out_adv;
    logic        emit;
    logic [14:0] rem_pat;
    logic [3:0]  rem_len;
    logic [3:0]  run_n;
    logic [3:0]  end_pos;
    logic [11:0] e_col;
    logic [7:0]  e_cnt;
    logic        e_last;

    assign out_adv = !r_out_valid || pop;
    assign emit    = i_job_valid && out_adv;

    // Find the run of equal bits at the current pattern position
    assign rem_pat = i_job.pat >> r_pos;
    assign rem_len = i_job.len - r_pos;

    always_comb begin
        run_n = rem_len;
        for (int j = 14; j >= 1; j--) begin
            if (4'(j) < rem_len && rem_pat[j] != rem_pat[0]) begin
                run_n = 4'(j);
            end
        end
    end

    assign end_pos = r_pos + run_n;

    // Select the run to emit
    always_comb begin
        if (i_job.mono) begin
            e_col  = rem_pat[0] ? i_job.col1 : i_job.col0;
            e_cnt  = {4'd0, run_n};
            e_last = (end_pos == i_job.len);
        end else if (r_pos == 4'd0) begin
            e_col  = i_job.col0;
            e_cnt  = i_job.cnt0;
            e_last = !i_job.two;
        end else begin
            e_col  = i_job.col1;
            e_cnt  = i_job.cnt1;
            e_last = 1'b1;
        end
    end

    assign o_job_pop = emit && e_last;

    // Advance position within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
        end else if (emit) begin
            if (e_last) begin
                r_pos <= 4'd0;
            end else if (i_job.mono) begin
                r_pos <= end_pos;
            end else begin
                r_pos <= 4'd1;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_col  <= e_col;
            r_out_cnt  <= e_cnt;
            r_out_last <= e_last;
        end
    end

    assign empty          = !r_out_valid;
    assign o_pixel_color  = r_out_col;
    assign o_repeat_count = r_out_cnt;
    assign o_last_run     = r_out_last;

    `ASSERT_NOW(a_cnt_nonzero, i_clk, i_rst_n, r_out_valid, r_out_cnt != 8'd0)
    `ASSERT_NOW(a_pos_in_pat, i_clk, i_rst_n, i_job_valid && i_job.mono, r_pos < i_job.len)

endmodule
`default_nettype wire
